// ----- rtl/dbscan_pkg.sv -----
// dbscan_pkg: shared constants and state type for the dbscan clustering unit
// no dependencies
package dbscan_pkg;

    localparam int MaxPointsDef = 64;
    localparam int CoordBitsDef = 16;
    localparam int LabelW       = 7;
    localparam int EpsW         = 16;
    localparam int MinPtsW      = 7;
    localparam int ScaleW       = 16;

    // config register indexes
    localparam logic [1:0] RegEpsilon  = 2'd0;
    localparam logic [1:0] RegMinPts   = 2'd1;
    localparam logic [1:0] RegAdaptive = 2'd2;
    localparam logic [1:0] RegScale    = 2'd3;

    typedef enum logic [4:0] {
        ST_LOAD,      // accept points
        ST_CLR,       // clear labels
        ST_OUTER,     // pick next unlabeled point
        ST_RAD_RD,    // read center point
        ST_RAD_SQ,    // squares of center
        ST_RAD_SUM,   // sum of squares
        ST_RAD_SQRT,  // integer square root, one result bit per cycle
        ST_RAD_MUL,   // d * scale
        ST_RAD_ADD,   // radius add
        ST_RAD_FIN,   // radius squared
        ST_CNT,       // neighbor count sweep
        ST_CNT_END,   // core decision
        ST_GROW,      // label sweep
        ST_GROW_END,  // drain last compare
        ST_SEED_RD,   // read seed queue
        ST_SEED_WT,   // seed data arrives
        ST_OUT_RD,    // read label
        ST_OUT        // present label
    } dbs_state_t;

endpackage

// ----- rtl/dbscan_point_clustering_unit.sv -----
// DBSCAN point clustering unit: top level with point, label and seed memories
// depends on dbscan_pkg
// Flow: points load one per cycle while in_stall is low; after the last point the labels are
// cleared, then each unlabeled point gets a radius (with a square root in adaptive mode) and a
// neighbor count sweep, and core points grow a cluster; labels then leave one at a time.
// Throughput: one point cloud at a time, input stalls from the last point to the last label.
// Reset: asynchronous active low; clears control, config to defaults, empties store.
module dbscan_point_clustering_unit
    import dbscan_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDef,
    parameter int COORD_BITS = CoordBitsDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  logic signed [COORD_BITS-1:0] z,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [LabelW-1:0]            cluster_label,
    output logic                         last_label
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = AW + 1;
    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * DW;
    localparam int SSW = SQW + 2;
    localparam int RTW = (SSW + 1) / 2;
    // radius is eps plus a term no wider than the root
    localparam int RW  = ((EpsW > RTW) ? EpsW : RTW) + 1;
    localparam int R2W = 2 * RW;
    localparam int PW  = 3 * COORD_BITS;
    localparam int NW  = (CW > MinPtsW) ? CW : MinPtsW;

    // config registers
    logic [EpsW-1:0]    eps_reg;
    logic [MinPtsW-1:0] minpts_reg;
    logic               adapt_reg;
    logic [ScaleW-1:0]  scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= EpsW'(256);
            minpts_reg <= MinPtsW'(4);
            adapt_reg  <= 1'b0;
            scale_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegEpsilon:  eps_reg    <= cfg_data[EpsW-1:0];
                RegMinPts:   minpts_reg <= cfg_data[MinPtsW-1:0];
                RegAdaptive: adapt_reg  <= cfg_data[0];
                RegScale:    scale_reg  <= cfg_data[ScaleW-1:0];
                default:     ;
            endcase
        end
    end

    // memories
    logic [PW-1:0]     pmem [MAX_POINTS];
    logic [LabelW-1:0] lmem [MAX_POINTS];
    logic [AW-1:0]     qmem [MAX_POINTS];

    logic              p_we;
    logic [AW-1:0]     p_wa, p_ra;
    logic [PW-1:0]     p_wd, p_rd;
    logic              l_we;
    logic [AW-1:0]     l_wa, l_ra;
    logic [LabelW-1:0] l_wd, l_rd;
    logic              q_we;
    logic [AW-1:0]     q_wa, q_ra;
    logic [AW-1:0]     q_rd;
    logic [AW-1:0]     q_wd_c;

    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_wa] <= p_wd;
        p_rd <= pmem[p_ra];
        if (l_we)
            lmem[l_wa] <= l_wd;
        l_rd <= lmem[l_ra];
        if (q_we)
            qmem[q_wa] <= q_wd_c;
        q_rd <= qmem[q_ra];
    end

    // control registers
    dbs_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [LabelW-1:0] clus_reg, clus_next;
    logic [AW-1:0]     outer_reg, outer_next;   // outer scan index
    logic [CW-1:0]     j_reg, j_next;           // sweep index
    logic [CW-1:0]     head_reg, head_next;
    logic [CW-1:0]     tail_reg, tail_next;
    logic              seed_reg, seed_next;     // 0 = outer core, 1 = seed
    logic              pv_reg, pv_next;         // compare pipe valid
    logic [AW-1:0]     pj_reg, pj_next;
    logic [CW-1:0]     ncnt_reg, ncnt_next;
    logic [5:0]        it_reg, it_next;
    logic              ov_reg, ov_next;
    logic              ol_reg, ol_next;
    logic [LabelW-1:0] olab_reg, olab_next;

    // datapath registers
    logic [PW-1:0]     cp_reg, cp_next;
    logic [SQW-1:0]    sx_reg, sy_reg, sz_reg;
    logic [SQW-1:0]    sx_next, sy_next, sz_next;
    logic [SSW-1:0]    rem_reg, rem_next;
    logic [RTW-1:0]    root_reg, root_next;
    logic [SSW-1:0]    val_reg, val_next;
    logic [RTW+ScaleW-1:0] prod_reg, prod_next;
    logic [RW-1:0]     rad_reg, rad_next;
    logic [R2W-1:0]    r2_reg, r2_next;
    logic [SSW-1:0]    d2_reg;
    logic              d2v_reg;
    logic [AW-1:0]     d2j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            clus_reg  <= LabelW'(1);
            outer_reg <= '0;
            j_reg     <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            seed_reg  <= 1'b0;
            pv_reg    <= 1'b0;
            pj_reg    <= '0;
            ncnt_reg  <= '0;
            it_reg    <= '0;
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
            olab_reg  <= '0;
            d2v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clus_reg  <= clus_next;
            outer_reg <= outer_next;
            j_reg     <= j_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            seed_reg  <= seed_next;
            pv_reg    <= pv_next;
            pj_reg    <= pj_next;
            ncnt_reg  <= ncnt_next;
            it_reg    <= it_next;
            ov_reg    <= ov_next;
            ol_reg    <= ol_next;
            olab_reg  <= olab_next;
            d2v_reg   <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sz_reg   <= sz_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
        prod_reg <= prod_next;
        rad_reg  <= rad_next;
        r2_reg   <= r2_next;
        d2_reg   <= SSW'(sx_next) + SSW'(sy_next) + SSW'(sz_next);
        d2j_reg  <= pj_reg;
    end

    // coordinate deltas of a swept point against the center
    logic signed [COORD_BITS-1:0] cx, cy, cz, qx, qy, qz;
    logic signed [DW-1:0] dx, dy, dz;
    assign cx = cp_reg[PW-1 -: COORD_BITS];
    assign cy = cp_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign cz = cp_reg[COORD_BITS-1:0];
    assign qx = p_rd[PW-1 -: COORD_BITS];
    assign qy = p_rd[2*COORD_BITS-1 -: COORD_BITS];
    assign qz = p_rd[COORD_BITS-1:0];
    assign dx = DW'(cx) - DW'(qx);
    assign dy = DW'(cy) - DW'(qy);
    assign dz = DW'(cz) - DW'(qz);

    logic in_radius;
    assign in_radius = (R2W'(d2_reg) <= r2_reg);

    // core decision, neighbor count against min_points
    logic is_core;
    assign is_core = (NW'(ncnt_reg) >= NW'(minpts_reg));

    // restoring square root step
    logic [SSW-1:0] trial;
    logic [SSW-1:0] rem_sh;
    assign rem_sh = {rem_reg[SSW-3:0], val_reg[SSW-1 -: 2]};
    assign trial  = SSW'({root_reg, 2'b01});

    logic [CW-1:0] tail_inc;
    assign tail_inc = tail_reg + CW'(1);

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        clus_next  = clus_reg;
        outer_next = outer_reg;
        j_next     = j_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        seed_next  = seed_reg;
        pv_next    = 1'b0;
        pj_next    = j_reg[AW-1:0];
        ncnt_next  = ncnt_reg;
        it_next    = it_reg;
        ov_next    = ov_reg;
        ol_next    = ol_reg;
        olab_next  = olab_reg;
        cp_next    = cp_reg;
        sx_next    = SQW'(dx * dx);
        sy_next    = SQW'(dy * dy);
        sz_next    = SQW'(dz * dz);
        rem_next   = rem_reg;
        root_next  = root_reg;
        val_next   = val_reg;
        prod_next  = prod_reg;
        rad_next   = rad_reg;
        r2_next    = r2_reg;
        p_we = 1'b0; p_wa = count_reg[AW-1:0];
        p_wd = {x, y, z};
        p_ra = j_reg[AW-1:0];
        l_we = 1'b0; l_wa = j_reg[AW-1:0]; l_wd = '0;
        l_ra = j_reg[AW-1:0];
        q_we = 1'b0; q_wa = tail_reg[AW-1:0]; q_wd_c = d2j_reg;
        q_ra = head_reg[AW-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < CW'(MAX_POINTS))
                    begin
                        p_we = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (last_point)
                    begin
                        j_next = '0;
                        state_next = ST_CLR;
                    end
                end
            end
            ST_CLR:
            begin
                if (j_reg == count_reg)
                begin
                    outer_next = '0;
                    j_next = '0;
                    state_next = (count_reg == '0) ? ST_OUT_RD : ST_OUTER;
                end
                else
                begin
                    l_we = 1'b1;
                    j_next = j_reg + CW'(1);
                end
            end
            ST_OUTER:
            begin
                // issue the label read of the outer point
                l_ra = outer_reg;
                state_next = ST_SEED_WT;
                seed_next = 1'b0;
            end
            ST_SEED_WT:
            begin
                // seed: q_rd valid; outer: l_rd valid
                if (seed_reg)
                begin
                    p_ra = q_rd;
                    state_next = ST_RAD_RD;
                end
                else if (l_rd != '0)
                begin
                    if (CW'(outer_reg) + CW'(1) == count_reg)
                    begin
                        j_next = '0;
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        outer_next = outer_reg + AW'(1);
                        state_next = ST_OUTER;
                    end
                end
                else
                begin
                    p_ra = outer_reg;
                    state_next = ST_RAD_RD;
                end
            end
            ST_RAD_RD:
            begin
                cp_next = p_rd;
                state_next = ST_RAD_SQ;
            end
            ST_RAD_SQ:
            begin
                sx_next = SQW'(cx * cx);
                sy_next = SQW'(cy * cy);
                sz_next = SQW'(cz * cz);
                state_next = ST_RAD_SUM;
            end
            ST_RAD_SUM:
            begin
                val_next  = SSW'(sx_reg) + SSW'(sy_reg) + SSW'(sz_reg);
                rem_next  = '0;
                root_next = '0;
                it_next   = '0;
                state_next = adapt_reg ? ST_RAD_SQRT : ST_RAD_ADD;
                prod_next = '0;
            end
            ST_RAD_SQRT:
            begin
                val_next = val_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RTW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RTW-2:0], 1'b0};
                end
                it_next = it_reg + 6'd1;
                if (it_reg == 6'(RTW - 1))
                    state_next = ST_RAD_MUL;
            end
            ST_RAD_MUL:
            begin
                prod_next = (RTW+ScaleW)'(root_reg) * (RTW+ScaleW)'(scale_reg);
                state_next = ST_RAD_ADD;
            end
            ST_RAD_ADD:
            begin
                rad_next = RW'(eps_reg) + RW'(prod_reg >> ScaleW);
                state_next = ST_RAD_FIN;
            end
            ST_RAD_FIN:
            begin
                r2_next = R2W'(rad_reg) * R2W'(rad_reg);
                j_next = '0;
                ncnt_next = '0;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                // sweep: read j, square next cycle, compare after
                if (j_reg != count_reg)
                begin
                    pv_next = 1'b1;
                    j_next = j_reg + CW'(1);
                end
                if (d2v_reg && in_radius)
                    ncnt_next = ncnt_reg + CW'(1);
                if (j_reg == count_reg && !pv_reg && !d2v_reg)
                    state_next = ST_CNT_END;
            end
            ST_CNT_END:
            begin
                j_next = '0;
                if (is_core)
                begin
                    if (!seed_reg)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    state_next = ST_GROW;
                end
                else
                    state_next = ST_SEED_RD;
            end
            ST_GROW:
            begin
                // label read aligns with distance (issued in the cycle after the p_rd read)
                if (j_reg != count_reg)
                begin
                    pv_next = 1'b1;
                    j_next = j_reg + CW'(1);
                end
                l_ra = pj_reg;
                if (d2v_reg && in_radius && (!seed_reg || l_rd == '0))
                begin
                    l_we = 1'b1;
                    l_wa = d2j_reg;
                    l_wd = clus_reg;
                    if (tail_reg < CW'(MAX_POINTS))
                    begin
                        q_we = 1'b1;
                        tail_next = tail_inc;
                    end
                end
                if (j_reg == count_reg && !pv_reg && !d2v_reg)
                    state_next = ST_SEED_RD;
            end
            ST_SEED_RD:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next = head_reg + CW'(1);
                    seed_next = 1'b1;
                    state_next = ST_SEED_WT;
                end
                else
                begin
                    // an empty queue after seeds closes the cluster
                    if (seed_reg)
                        clus_next = clus_reg + LabelW'(1);
                    if (CW'(outer_reg) + CW'(1) == count_reg)
                    begin
                        j_next = '0;
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        outer_next = outer_reg + AW'(1);
                        state_next = ST_OUTER;
                    end
                end
            end
            ST_OUT_RD:
            begin
                if (j_reg == count_reg)
                begin
                    count_next = '0;
                    clus_next = LabelW'(1);
                    state_next = ST_LOAD;
                end
                else
                begin
                    l_ra = j_reg[AW-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                l_ra = j_reg[AW-1:0];
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    olab_next = l_rd;
                    ol_next = (j_reg + CW'(1) == count_reg);
                end
                else if (!out_stall)
                begin
                    ov_next = 1'b0;
                    j_next = j_reg + CW'(1);
                    state_next = ST_OUT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall      = (state_reg != ST_LOAD);
        out_valid     = ov_reg;
        cluster_label = olab_reg;
        last_label    = ol_reg;
    end

endmodule

// ----- tb/dbscan_point_clustering_unit_tb.sv -----
// testbench for dbscan_point_clustering_unit: loads point clouds, predicts the
// dbscan labels of each cloud and checks them in order; depends on dbscan_pkg
module dbscan_point_clustering_unit_tb
    import dbscan_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS      = MaxPointsDef;
    localparam int IDLE_STOP = 3000000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } point_t;

    typedef struct {
        logic [LabelW-1:0] label;
        logic              last;
    } label_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic signed [15:0]  z;
    logic                last_point;
    logic                out_valid;
    logic                out_stall;
    logic [LabelW-1:0]   cluster_label;
    logic                last_label;

    dbscan_point_clustering_unit dut (.*);

    // model copy of the registers and the point store
    logic [EpsW-1:0]    eps_m;
    logic [MinPtsW-1:0] minpts_m;
    logic               adapt_m;
    logic [ScaleW-1:0]  scale_m;
    logic signed [15:0] cx[NPTS], cy[NPTS], cz[NPTS];
    int                 cloud_n;
    logic [LabelW-1:0]  lbl[NPTS];
    int                 seeds[NPTS];
    int                 cluster_id;

    point_t pend_q[$];
    label_t label_expect_q[$];
    int     fail_count;
    int     long_req_n;

    // clock generator
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned radius_sq(int i);
        longint unsigned e, d;
        longint          sx, sy, sz;
        e = eps_m;
        if (adapt_m)
        begin
            sx = cx[i];
            sy = cy[i];
            sz = cz[i];
            d = int_sqrt(sx * sx + sy * sy + sz * sz);
            e += (d * scale_m) >> 16;
        end
        return e * e;
    endfunction

    function automatic longint unsigned dist_sq(int a, int b);
        longint dx, dy, dz;
        dx = longint'(cx[a]) - longint'(cx[b]);
        dy = longint'(cy[a]) - longint'(cy[b]);
        dz = longint'(cz[a]) - longint'(cz[b]);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic int neighbor_count(int p, longint unsigned r2);
        int n;
        n = 0;
        for (int j = 0; j < cloud_n; j++)
            if (dist_sq(p, j) <= r2)
                n++;
        return n;
    endfunction

    // expand one cluster from a core point through the seed list
    function automatic void grow_cluster(int core, logic [LabelW-1:0] id);
        longint unsigned r2, rs;
        int              head, tail, s;
        r2 = radius_sq(core);
        head = 0;
        tail = 0;
        for (int j = 0; j < cloud_n; j++)
            if (dist_sq(core, j) <= r2)
            begin
                lbl[j] = id;
                if (tail < NPTS)
                    seeds[tail++] = j;
            end
        while (head < tail)
        begin
            s = seeds[head++];
            rs = radius_sq(s);
            if (neighbor_count(s, rs) >= minpts_m)
                for (int j = 0; j < cloud_n; j++)
                    if (dist_sq(s, j) <= rs && lbl[j] == 0)
                    begin
                        lbl[j] = id;
                        if (tail < NPTS)
                            seeds[tail++] = j;
                    end
        end
    endfunction

    // store one accepted point; on the last one cluster and queue the labels
    function automatic void take_point(point_t p);
        label_t e;
        if (cloud_n < NPTS)
        begin
            cx[cloud_n] = p.x;
            cy[cloud_n] = p.y;
            cz[cloud_n] = p.z;
            cloud_n++;
        end
        if (p.last)
        begin
            cluster_id = 1;
            for (int i = 0; i < cloud_n; i++)
                lbl[i] = '0;
            for (int i = 0; i < cloud_n; i++)
                if (lbl[i] == 0 && neighbor_count(i, radius_sq(i)) >= minpts_m)
                begin
                    grow_cluster(i, cluster_id[LabelW-1:0]);
                    cluster_id = (cluster_id + 1) & 8'h7f;
                end
            for (int i = 0; i < cloud_n; i++)
            begin
                e.label = lbl[i];
                e.last  = (i == cloud_n - 1);
                label_expect_q = {label_expect_q, e};
            end
            cloud_n = 0;
        end
    endfunction

    // point driver: bursts of random length with random gaps
    int     burst_left;
    int     gap_left;
    point_t drv_item;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            x          <= '0;
            y          <= '0;
            z          <= '0;
            last_point <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                drv_item.x = x;
                drv_item.y = y;
                drv_item.z = z;
                drv_item.last = last_point;
                take_point(drv_item);
            end
            if (in_valid && in_stall)
            begin
                // payload holds while stalled
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                drv_item = pend_q.pop_front();
                in_valid   <= 1'b1;
                x          <= drv_item.x;
                y          <= drv_item.y;
                z          <= drv_item.z;
                last_point <= drv_item.last;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // label receiver: changing stall pattern plus requested long hold-offs
    int stall_mode;
    int stall_cyc;
    int long_left;
    int long_seen;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode = 0;
            stall_cyc  = 0;
            long_left  = 0;
            long_seen  = 0;
        end
        else
        begin
            stall_cyc++;
            if (stall_cyc % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            if (long_seen != long_req_n)
            begin
                long_seen = long_req_n;
                long_left = 4000;
            end
            if (long_left > 0)
            begin
                long_left--;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 9) < 4);
            else if (stall_mode == 2)
                out_stall <= (stall_cyc % 3 == 0);
            else
                out_stall <= 1'b0;
        end
    end

    // label monitor
    label_t got_exp;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (label_expect_q.size() == 0)
            begin
                $error("unexpected label transaction: cluster_label %0d", cluster_label);
                fail_count++;
            end
            else
            begin
                got_exp = label_expect_q.pop_front();
                if (cluster_label !== got_exp.label)
                begin
                    $error("cluster_label expected %0d actual %0d",
                           got_exp.label, cluster_label);
                    fail_count++;
                end
                if (last_label !== got_exp.last)
                begin
                    $error("last_label expected %0d actual %0d", got_exp.last, last_label);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cyc;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cyc = 0;
        else
            quiet_cyc++;
        if (quiet_cyc >= IDLE_STOP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pend_q.size() > 0 || in_valid || label_expect_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            RegEpsilon:  eps_m    = val;
            RegMinPts:   minpts_m = val[MinPtsW-1:0];
            RegAdaptive: adapt_m  = val[0];
            RegScale:    scale_m  = val;
            default:     ;
        endcase
    endtask

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    task automatic add_point(int px, int py, int pz, bit lst);
        point_t p;
        p.x = clip16(px);
        p.y = clip16(py);
        p.z = clip16(pz);
        p.last = lst;
        pend_q = {pend_q, p};
    endtask

    // a cloud of a few blobs around random centers plus scattered noise
    task automatic add_cloud(int n, int spread);
        int ctr[3][3];
        int nc, k;
        nc = $urandom_range(1, 3);
        for (int c = 0; c < nc; c++)
            for (int a = 0; a < 3; a++)
                ctr[c][a] = $signed($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, nc - 1);
            if ($urandom_range(0, 7) == 0)
                add_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                          $urandom_range(0, 65535) - 32768, i == n - 1);
            else
                add_point(ctr[k][0] + $urandom_range(0, 2 * spread) - spread,
                          ctr[k][1] + $urandom_range(0, 2 * spread) - spread,
                          ctr[k][2] + $urandom_range(0, 2 * spread) - spread, i == n - 1);
        end
    endtask

    // stimulus sequence
    int sent;
    int ng;
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        eps_m      = 16'd256;
        minpts_m   = 7'd4;
        adapt_m    = 1'b0;
        scale_m    = '0;
        cloud_n    = 0;
        fail_count = 0;
        long_req_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // single point cloud: never a core point at reset settings
        add_point(0, 0, 0, 1);
        wait_idle();
        // tight group of four plus the field extremes
        add_point(0, 0, 0, 0);
        add_point(100, 0, 0, 0);
        add_point(0, 100, 0, 0);
        add_point(0, 0, 100, 0);
        add_point(32767, 32767, 32767, 0);
        add_point(-32768, -32768, -32768, 1);
        wait_idle();
        // min_points of one and of zero: everything is core
        write_reg(RegMinPts, 16'd1);
        add_point(-32768, 32767, 0, 0);
        add_point(32767, -32768, 0, 1);
        wait_idle();
        write_reg(RegMinPts, 16'd0);
        add_point(5, 5, 5, 0);
        add_point(-5, -5, -5, 1);
        wait_idle();
        // wide write keeps the low bits: min_points above the count
        write_reg(RegMinPts, 16'hffff);
        add_point(1, 1, 1, 0);
        add_point(2, 2, 2, 1);
        wait_idle();
        // adaptive radius with zero base and largest scale
        write_reg(RegMinPts, 16'd2);
        write_reg(RegEpsilon, 16'd0);
        write_reg(RegAdaptive, 16'd1);
        write_reg(RegScale, 16'hffff);
        add_point(20000, 0, 0, 0);
        add_point(25000, 0, 0, 0);
        add_point(-300, 0, 0, 0);
        add_point(300, 0, 0, 1);
        wait_idle();
        // largest base radius, fixed mode
        write_reg(RegAdaptive, 16'd0);
        write_reg(RegEpsilon, 16'hffff);
        add_point(-32768, 0, 0, 0);
        add_point(32767, 0, 0, 1);
        wait_idle();

        // store full: points beyond capacity are dropped
        write_reg(RegEpsilon, 16'd400);
        write_reg(RegMinPts, 16'd3);
        add_cloud(NPTS + 2, 300);
        wait_idle();

        // random clouds, a few back to back, settings changed between groups
        sent = 0;
        while (sent < 370)
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(RegEpsilon, 16'hffff);
                1:       write_reg(RegEpsilon, 16'd0);
                2:       write_reg(RegEpsilon, $urandom_range(0, 65535));
                default: write_reg(RegEpsilon, $urandom_range(64, 1024));
            endcase
            write_reg(RegMinPts, ($urandom_range(0, 9) == 0) ? 16'hffff : $urandom_range(0, 6));
            write_reg(RegAdaptive, $urandom_range(0, 65535));
            write_reg(RegScale, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 4096));
            // once, hold off labels while the following clouds are offered
            if (sent > 150 && long_req_n == 0)
            begin
                long_req_n++;
                ng = 3;
            end
            else
                ng = $urandom_range(1, 3);
            for (int g = ng; g > 0; g--)
            begin
                int n;
                n = $urandom_range(1, 12);
                add_cloud(n, $urandom_range(32, 600));
                sent += n;
            end
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dbscan_pkg.sv
rtl/dbscan_point_clustering_unit.sv
tb/dbscan_point_clustering_unit_tb.sv
